// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the scheduler blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_CLK(lbl, !(expr), msg)

`endif

// File: rtl/ptts_pkg.sv
// ----------------------------------------------------------------------------
// ptts_pkg
// Types, codes and default sizes shared by the tick scheduler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptts_pkg;

	localparam int PTTS_TIMERS        = 4;
	localparam int PTTS_SLOTS         = 10;
	localparam int PTTS_INTERVAL_BITS = 16;
	localparam int PTTS_ID_BITS       = 8;

	localparam logic OP_REGISTER = 1'b0;
	localparam logic OP_TICK     = 1'b1;

	typedef enum logic [1:0] {
		KIND_STATUS = 2'd0,
		KIND_FIRED  = 2'd1,
		KIND_QUIET  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_ARG   = 2'd1,
		STAT_DUPLICATE = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREP,
		S_WALK,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic prep;
		logic step;
		logic finish;
	} ptts_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bad;
		logic empty;
		logic fire;
		logic pend;
		logic last_slot;
		logic out_free;
	} ptts_sts_t;

endpackage

// File: rtl/ptts_ram.sv
// ----------------------------------------------------------------------------
// ptts_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/ptts_ctrl.sv
// ----------------------------------------------------------------------------
// ptts_ctrl
// Sequencer for one item at a time: prepare, walk the slots, deliver the end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptts_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ptts_pkg::ptts_sts_t sts,
	output ptts_pkg::ptts_cmd_t cmd
);

	import ptts_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   advance;

	// A walk step stalls only when it must hand an earlier firing to a full output.
	assign advance = !(sts.fire && sts.pend) || sts.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_PREP;
			end
			S_PREP: begin
				if (sts.bad || sts.empty) state_d = S_FINISH;
				else state_d = S_WALK;
			end
			S_WALK: begin
				if (advance && sts.last_slot) state_d = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_PREP: begin
				cmd.prep = !(sts.bad || sts.empty);
			end
			S_WALK: begin
				cmd.step = advance;
			end
			S_FINISH: begin
				cmd.finish = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: rtl/ptts_dp.sv
// ----------------------------------------------------------------------------
// ptts_dp
// Datapath: item registers, fill counts, slot RAM, pending firing and output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ptts_dp #(
	parameter int TIMERS        = ptts_pkg::PTTS_TIMERS,
	parameter int SLOTS         = ptts_pkg::PTTS_SLOTS,
	parameter int INTERVAL_BITS = ptts_pkg::PTTS_INTERVAL_BITS,
	parameter int ID_BITS       = ptts_pkg::PTTS_ID_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ptts_pkg::ptts_cmd_t cmd,
	output ptts_pkg::ptts_sts_t sts,
	input  logic                in_opcode,
	input  logic [2:0]          in_timer,
	input  logic [7:0]          in_task_id,
	input  logic [15:0]         in_interval,
	output logic                out_valid,
	input  logic                out_ready,
	output ptts_pkg::kind_t     out_kind,
	output ptts_pkg::status_t   out_status,
	output logic [7:0]          out_fired_id,
	output logic [2:0]          out_timer,
	output logic                out_last
);

	import ptts_pkg::*;

	localparam int CELLS = TIMERS * SLOTS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int SW    = $clog2(SLOTS + 1);
	localparam int TW    = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int WW    = ID_BITS + 2 * INTERVAL_BITS;

	logic                     op_q;
	logic [2:0]               timer_q;
	logic [ID_BITS-1:0]       id_q;
	logic [INTERVAL_BITS-1:0] iv_q;
	logic [AW-1:0]            base_q;
	logic [SW-1:0]            slot_q;
	logic                     match_q;
	logic                     pend_q;
	logic [ID_BITS-1:0]       pend_id_q;
	logic [SW-1:0]            fill_q [TIMERS];

	logic                     m_valid_q;
	kind_t                    m_kind_q;
	status_t                  m_status_q;
	logic [7:0]               m_fired_q;
	logic [2:0]               m_timer_q;
	logic                     m_last_q;

	logic [ID_BITS+7:0]       id_ext;
	logic [INTERVAL_BITS+15:0] iv_ext;
	logic [ID_BITS+7:0]       fid_ext;
	logic [TW-1:0]            tsel;
	logic                     bad_w;
	logic [SW-1:0]            n_w;
	logic [SW-1:0]            next_slot;
	status_t                  reg_status;
	logic                     commit;
	logic                     out_free;
	logic                     push_step;

	logic                     rd_en;
	logic [AW-1:0]            rd_addr;
	logic [WW-1:0]            rd_data;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [WW-1:0]            wr_data;
	logic [ID_BITS-1:0]       rd_id;
	logic [INTERVAL_BITS-1:0] rd_iv;
	logic [INTERVAL_BITS-1:0] rd_cnt;
	logic [INTERVAL_BITS-1:0] cnt_inc;
	logic                     fire_w;

	// Input fields are taken at the configured widths, zero-extended or truncated.
	assign id_ext  = {{ID_BITS{1'b0}}, in_task_id};
	assign iv_ext  = {{INTERVAL_BITS{1'b0}}, in_interval};
	assign fid_ext = {8'd0, pend_id_q};

	assign tsel  = timer_q[TW-1:0];
	assign bad_w = ({1'b0, timer_q} >= 4'(TIMERS)) ||
		(op_q == OP_REGISTER && (id_q == '0 || iv_q == '0));
	assign n_w   = bad_w ? '0 : fill_q[tsel];

	assign rd_id   = rd_data[WW-1 -: ID_BITS];
	assign rd_iv   = rd_data[2*INTERVAL_BITS-1 -: INTERVAL_BITS];
	assign rd_cnt  = rd_data[INTERVAL_BITS-1:0];
	assign cnt_inc = rd_cnt + INTERVAL_BITS'(1);
	assign fire_w  = (op_q == OP_TICK) && (cnt_inc >= rd_iv);

	always_comb begin
		priority if (bad_w) reg_status = STAT_BAD_ARG;
		else if (match_q) reg_status = STAT_DUPLICATE;
		else if (n_w == SW'(SLOTS)) reg_status = STAT_FULL;
		else reg_status = STAT_OK;
	end

	assign commit    = cmd.finish && (op_q == OP_REGISTER) && (reg_status == STAT_OK);
	assign out_free  = !m_valid_q || out_ready;
	assign push_step = cmd.step && fire_w && pend_q;

	// Slots are walked from the newest down; the read of the next slot
	// overlaps the evaluation and write-back of the current one.
	assign next_slot = cmd.prep ? (n_w - SW'(1)) : (slot_q - SW'(1));
	assign rd_en     = cmd.prep || (cmd.step && slot_q != '0);
	assign rd_addr   = base_q + AW'(next_slot);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = base_q + AW'(slot_q);
		wr_data = {rd_id, rd_iv, (fire_w ? {INTERVAL_BITS{1'b0}} : cnt_inc)};
		if (commit) begin
			wr_en   = 1'b1;
			wr_addr = base_q + AW'(n_w);
			wr_data = {id_q, iv_q, {INTERVAL_BITS{1'b0}}};
		end else if (cmd.step && op_q == OP_TICK) begin
			wr_en = 1'b1;
		end
	end

	ptts_ram #(
		.WIDTH (WW),
		.DEPTH (CELLS),
		.AW    (AW)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_opcode;
			timer_q <= in_timer;
			id_q    <= id_ext[ID_BITS-1:0];
			iv_q    <= iv_ext[INTERVAL_BITS-1:0];
			base_q  <= AW'({29'd0, in_timer} * SLOTS);
		end
		if (cmd.prep || cmd.step) begin
			slot_q <= next_slot;
		end
		if (cmd.step && fire_w) begin
			pend_id_q <= rd_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			pend_q  <= 1'b0;
			for (int t = 0; t < TIMERS; t++) begin
				fill_q[t] <= '0;
			end
		end else begin
			if (cmd.load) begin
				match_q <= 1'b0;
				pend_q  <= 1'b0;
			end else if (cmd.step) begin
				if (op_q == OP_REGISTER && rd_id == id_q) match_q <= 1'b1;
				if (fire_w) pend_q <= 1'b1;
			end
			if (commit) begin
				fill_q[tsel] <= n_w + SW'(1);
			end
		end
	end

	// Output register: an earlier firing leaves when a later one is found,
	// and the end of the item carries the final result with last set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (push_step || cmd.finish) begin
			m_valid_q <= 1'b1;
		end else if (out_ready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_step) begin
			m_kind_q   <= KIND_FIRED;
			m_status_q <= STAT_OK;
			m_fired_q  <= fid_ext[7:0];
			m_timer_q  <= timer_q;
			m_last_q   <= 1'b0;
		end else if (cmd.finish) begin
			m_timer_q <= timer_q;
			m_last_q  <= 1'b1;
			if (op_q == OP_REGISTER) begin
				m_kind_q   <= KIND_STATUS;
				m_status_q <= reg_status;
				m_fired_q  <= 8'd0;
			end else if (bad_w) begin
				m_kind_q   <= KIND_QUIET;
				m_status_q <= STAT_BAD_ARG;
				m_fired_q  <= 8'd0;
			end else if (pend_q) begin
				m_kind_q   <= KIND_FIRED;
				m_status_q <= STAT_OK;
				m_fired_q  <= fid_ext[7:0];
			end else begin
				m_kind_q   <= KIND_QUIET;
				m_status_q <= STAT_OK;
				m_fired_q  <= 8'd0;
			end
		end
	end

	assign sts.bad       = bad_w;
	assign sts.empty     = (n_w == '0);
	assign sts.fire      = fire_w;
	assign sts.pend      = pend_q;
	assign sts.last_slot = (slot_q == '0);
	assign sts.out_free  = out_free;

	assign out_valid    = m_valid_q;
	assign out_kind     = m_kind_q;
	assign out_status   = m_status_q;
	assign out_fired_id = m_fired_q;
	assign out_timer    = m_timer_q;
	assign out_last     = m_last_q;

	`ASSERT_NEVER(a_no_overwrite, (push_step || cmd.finish) && !out_free, "result overwritten")
	`ASSERT_NEVER(a_port_clash, wr_en && rd_en && (wr_addr == rd_addr), "slot port clash")
	`ASSERT_CLK(a_fill_range, cmd.finish |-> n_w <= SW'(SLOTS), "timer fill beyond slots")
	`ASSERT_CLK(a_finish_out, cmd.finish |=> m_valid_q && m_last_q, "final result missing")

endmodule

// File: rtl/periodic_task_tick_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Per-timer table of periodic tasks, driven by register and tick items.
// ----------------------------------------------------------------------------
// The block keeps TIMERS timers with SLOTS task slots each. A register item
// (tuser low) adds a task id and interval to a timer and always answers with
// one status result. A tick item (tuser high) walks that timer's tasks from
// the newest to the oldest, bumps every counter and reports each task whose
// counter reaches its interval, in walk order, with tlast on the final one;
// a tick that fires nothing, or names a timer out of range, gives one quiet
// result. Items are handled one at a time. The slot RAM has a single read
// port and the walk reads one slot per cycle while output back-pressure does
// not hold it; an item with a bad argument or for an empty timer skips the
// walk. Output back-pressure stalls the walk when a firing must be handed
// over, and delays the final result, while the previous result is still
// waiting.
// The slot RAM needs no clearing pass: only slots below a timer's fill count,
// which resets to zero, are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_task_tick_scheduler #(
	parameter int TIMERS        = ptts_pkg::PTTS_TIMERS,
	parameter int SLOTS         = ptts_pkg::PTTS_SLOTS,
	parameter int INTERVAL_BITS = ptts_pkg::PTTS_INTERVAL_BITS,
	parameter int ID_BITS       = ptts_pkg::PTTS_ID_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input items.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // timer[2:0], task_id[10:3], interval[26:11]
	input  logic        s_axis_tuser,  // opcode: 0 register, 1 tick
	// Result items.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // kind[1:0], status[3:2], fired_id[11:4],
	                                   // timer_echo[14:12]
	output logic        m_axis_tlast
);

	import ptts_pkg::*;

	ptts_cmd_t cmd;
	ptts_sts_t sts;
	kind_t     out_kind;
	status_t   out_status;
	logic [7:0] out_fired_id;
	logic [2:0] out_timer;

	// The controller sequences each item; the datapath holds the item, fill and
	// output registers and the slot RAM, and reports back what the controller needs to steer.
	ptts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ptts_dp #(
		.TIMERS        (TIMERS),
		.SLOTS         (SLOTS),
		.INTERVAL_BITS (INTERVAL_BITS),
		.ID_BITS       (ID_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_opcode    (s_axis_tuser),
		.in_timer     (s_axis_tdata[2:0]),
		.in_task_id   (s_axis_tdata[10:3]),
		.in_interval  (s_axis_tdata[26:11]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_kind     (out_kind),
		.out_status   (out_status),
		.out_fired_id (out_fired_id),
		.out_timer    (out_timer),
		.out_last     (m_axis_tlast)
	);

	// Result fields packed from the lowest bit up, padded to whole bytes.
	assign m_axis_tdata = {1'b0, out_timer, out_fired_id, out_status, out_kind};

endmodule
